// ===== rtl/dq_pkg.sv =====
`default_nettype none

package dq_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned STATUS_W = 2;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    // Result of one operation, except the occupancy whose width follows DEPTH.
    typedef struct packed {
        t_data   popped;
        t_status status;
        t_data   front;
        t_data   back;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/dq_store.sv =====
`default_nettype none

module dq_store #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_wr_en,
    input  wire logic [AW-1:0]  i_wr_addr,
    input  wire dq_pkg::t_data  i_wr_data,
    input  wire logic           i_rd_en,
    input  wire logic [AW-1:0]  i_rd_addr,
    output dq_pkg::t_data       o_rd_data
);

    dq_pkg::t_data r_mem [DEPTH];
    dq_pkg::t_data r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/dq_ctrl.sv =====
`default_nettype none

module dq_ctrl #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8,
    parameter int unsigned CW    = 9
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire dq_pkg::t_op    i_kind,
    input  wire dq_pkg::t_data  i_data,
    output logic                o_busy,
    output logic                o_done,
    output dq_pkg::t_res        o_res,
    output logic [CW-1:0]       o_occ,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output dq_pkg::t_data       o_wr_data,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr,
    input  wire dq_pkg::t_data  i_rd_data
);

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    dq_pkg::t_state r_state, n_state;
    logic [AW-1:0]  r_head, n_head;
    logic [AW-1:0]  r_tail, n_tail;
    logic [CW-1:0]  r_count, n_count;
    dq_pkg::t_data  r_front, n_front;
    dq_pkg::t_data  r_back, n_back;
    dq_pkg::t_data  r_popped, n_popped;
    logic           r_pop_front, n_pop_front;

    logic [AW-1:0]  head_inc, head_dec, tail_inc, tail_dec, tail_dec2;
    logic           is_empty, is_full, is_last;
    logic           need_read;
    dq_pkg::t_status res_status;

    assign head_inc  = (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
    assign head_dec  = (r_head == '0) ? LAST_SLOT : r_head - AW'(1);
    assign tail_inc  = (r_tail == LAST_SLOT) ? '0 : r_tail + AW'(1);
    assign tail_dec  = (r_tail == '0) ? LAST_SLOT : r_tail - AW'(1);
    assign tail_dec2 = (tail_dec == '0) ? LAST_SLOT : tail_dec - AW'(1);

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == FULL_CNT);
    assign is_last  = (r_count == CW'(1));

    // A pop that leaves at least one item must fetch the new end item.
    assign need_read = i_accept && !is_last && !is_empty &&
                       ((i_kind == dq_pkg::OP_POP_FRONT) || (i_kind == dq_pkg::OP_POP_BACK));

    always_comb begin
        n_state = r_state;
        case (r_state)
            dq_pkg::ST_IDLE: begin
                if (need_read) begin
                    n_state = dq_pkg::ST_READ;
                end
            end
            dq_pkg::ST_READ: begin
                n_state = dq_pkg::ST_IDLE;
            end
            default: begin
                n_state = dq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_front     = r_front;
        n_back      = r_back;
        n_popped    = r_popped;
        n_pop_front = r_pop_front;
        res_status  = dq_pkg::STAT_OK;
        o_done      = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_tail;
        o_wr_data   = i_data;
        o_rd_en     = 1'b0;
        o_rd_addr   = head_inc;
        o_busy      = (r_state != dq_pkg::ST_IDLE);

        if (r_state == dq_pkg::ST_READ) begin
            if (r_pop_front) begin
                n_front = i_rd_data;
            end else begin
                n_back = i_rd_data;
            end
            o_done = 1'b1;
        end else if (i_accept) begin
            n_popped = '0;
            case (i_kind)
                dq_pkg::OP_PUSH_FRONT: begin
                    o_done = 1'b1;
                    if (is_full) begin
                        res_status = dq_pkg::STAT_FULL;
                    end else begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = head_dec;
                        n_head    = head_dec;
                        n_count   = r_count + CW'(1);
                        n_front   = i_data;
                        if (is_empty) begin
                            n_back = i_data;
                        end
                    end
                end
                dq_pkg::OP_PUSH_BACK: begin
                    o_done = 1'b1;
                    if (is_full) begin
                        res_status = dq_pkg::STAT_FULL;
                    end else begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_tail;
                        n_tail    = tail_inc;
                        n_count   = r_count + CW'(1);
                        n_back    = i_data;
                        if (is_empty) begin
                            n_front = i_data;
                        end
                    end
                end
                dq_pkg::OP_POP_FRONT: begin
                    if (is_empty) begin
                        res_status = dq_pkg::STAT_EMPTY;
                        o_done     = 1'b1;
                    end else begin
                        n_popped    = r_front;
                        n_head      = head_inc;
                        n_count     = r_count - CW'(1);
                        n_pop_front = 1'b1;
                        if (is_last) begin
                            n_front = '0;
                            n_back  = '0;
                            o_done  = 1'b1;
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = head_inc;
                        end
                    end
                end
                dq_pkg::OP_POP_BACK: begin
                    if (is_empty) begin
                        res_status = dq_pkg::STAT_EMPTY;
                        o_done     = 1'b1;
                    end else begin
                        n_popped    = r_back;
                        n_tail      = tail_dec;
                        n_count     = r_count - CW'(1);
                        n_pop_front = 1'b0;
                        if (is_last) begin
                            n_front = '0;
                            n_back  = '0;
                            o_done  = 1'b1;
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = tail_dec2;
                        end
                    end
                end
                default: begin
                    o_done = 1'b1;
                end
            endcase
        end

        o_res.popped = n_popped;
        o_res.status = res_status;
        o_res.front  = n_front;
        o_res.back   = n_back;
        o_occ        = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dq_pkg::ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_front <= '0;
            r_back  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_front <= n_front;
            r_back  <= n_back;
        end
    end

    always_ff @(posedge i_clk) begin
        r_popped    <= n_popped;
        r_pop_front <= n_pop_front;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("item count above depth");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_front == '0 && r_back == '0))
        else $error("empty queue holds nonzero end items");

    a_single_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(1) && r_state == dq_pkg::ST_IDLE) |-> (r_front == r_back))
        else $error("single item queue has different end items");

    a_read_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dq_pkg::ST_READ) |-> $past(i_accept))
        else $error("read cycle without an accepted pop");
`endif

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
`default_nettype none

// Channel   Dir  Signals                          Contents
// s_*       in   s_tvalid s_tready s_tdata s_tuser  operation kind and item to push
// m_*       out  m_tvalid m_tready m_tdata          popped item, status, occupancy, ends
//
// Pushes, rejected pushes and pops that need no memory fetch complete in the cycle they are taken.
// A pop from a queue holding two or more items also passes through the read state, since the new end
// item is fetched through the single read port of the item memory, whose read data is registered.
// i_rst_n is synchronous and active low; it empties the queue and drops any held result.
// The memory needs no clearing pass: only entries written by a push are ever read.
// A result waits in the output register; a new item is taken while it is drained.

module double_ended_queue #(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [31:0]          s_tdata,  // [31:0] data_in
    input  wire logic [1:0]           s_tuser,  // [1:0] kind
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // m_tdata: popped_value, status, occupancy, front_value, back_value, zero fill
    output logic [((3*dq_pkg::DATA_W + dq_pkg::STATUS_W + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0]
                                      m_tdata
);

    localparam int unsigned AW     = $clog2(DEPTH);
    localparam int unsigned CW     = $clog2(DEPTH + 1);
    localparam int unsigned PACK_W = 3 * dq_pkg::DATA_W + dq_pkg::STATUS_W + CW;
    localparam int unsigned TDW    = ((PACK_W + 7) / 8) * 8;

    logic            accept;
    logic            busy;
    logic            done;
    dq_pkg::t_res    res;
    logic [CW-1:0]   occ;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    dq_pkg::t_data   wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    dq_pkg::t_data   rd_data;

    logic            r_out_valid;
    logic [TDW-1:0]  r_out_data;

    // The engine takes an item when it is not fetching and the output register
    // is free or being emptied in this same cycle.
    assign s_tready = !busy && (!r_out_valid || m_tready);
    assign accept   = s_tvalid && s_tready;

    dq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_kind    (dq_pkg::t_op'(s_tuser)),
        .i_data    (dq_pkg::t_data'(s_tdata)),
        .o_busy    (busy),
        .o_done    (done),
        .o_res     (res),
        .o_occ     (occ),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    // Item memory. A pop never writes, and every read targets an entry written in
    // an earlier cycle, so reads and writes never collide on one entry.
    dq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register. When a result completes, the register is known to be free,
    // because the item that produced it was only taken with the register free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_data <= TDW'({res.back, res.front, occ, res.status, res.popped});
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_done_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> (!r_out_valid || m_tready))
        else $error("result completed while the output register was held");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("waiting result changed before it was taken");

    a_fetch_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("memory fetch lasted more than one cycle");
`endif

endmodule

`default_nettype wire

// ===== tb/double_ended_queue_test.sv =====
`timescale 1ns / 100ps

module double_ended_queue_test;

    // The block is tested at its default size.
    localparam int unsigned DEPTH = 256;
    localparam int unsigned SLOT_W = $clog2(DEPTH);
    localparam int unsigned OCC_W = $clog2(DEPTH + 1);
    localparam int unsigned RES_W =
        ((3 * dq_pkg::DATA_W + dq_pkg::STATUS_W + OCC_W + 7) / 8) * 8;

    // Field positions inside m_tdata, from the lowest bit up.
    localparam int unsigned POPPED_LSB = 0;
    localparam int unsigned STATUS_LSB = POPPED_LSB + dq_pkg::DATA_W;
    localparam int unsigned OCC_LSB = STATUS_LSB + dq_pkg::STATUS_W;
    localparam int unsigned FRONT_LSB = OCC_LSB + OCC_W;
    localparam int unsigned BACK_LSB = FRONT_LSB + dq_pkg::DATA_W;

    // The slowest correct run stays far below this many cycles.
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RESET_CYCLES = 8;
    localparam int unsigned SETTLE_CYCLES = 20;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [OCC_W-1:0] t_occ;

    // One expected or observed result item of the queue.
    typedef struct {
        dq_pkg::t_data   popped;
        dq_pkg::t_status status;
        t_occ            occupancy;
        dq_pkg::t_data   front;
        dq_pkg::t_data   back;
    } t_reply;

    // One operation waiting to be sent. When wait_idle is set, the sender holds
    // it back until every result of the earlier operations has come out.
    typedef struct {
        dq_pkg::t_op   op;
        dq_pkg::t_data value;
        bit            wait_idle;
    } t_queued_op;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;     // [31:0] data_in
    logic [1:0] s_tuser = '0;      // [1:0] kind
    logic m_tvalid;
    logic m_tready = 1'b0;
    // [31:0] popped_value, [33:32] status, [42:34] occupancy,
    // [74:43] front_value, [106:75] back_value, then zero fill.
    logic [RES_W-1:0] m_tdata;

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Operations not yet sent, and results predicted but not yet seen.
    t_queued_op op_backlog[$];
    t_reply replies_due[$];

    // Shadow copy of the queue contents that the prediction works on.
    dq_pkg::t_data ring_mem[DEPTH];
    t_slot ring_head = '0;
    t_slot ring_tail = '0;
    t_occ ring_count = '0;

    // Occupancy as the stimulus generator expects it when building sequences.
    int unsigned planned_count = 0;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    int unsigned send_gap = 0;
    int unsigned send_calm = 0;
    int unsigned recv_stall = 0;
    int unsigned recv_calm = 0;

    function automatic t_slot slot_next(t_slot s);
        return (s == t_slot'(DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic t_slot slot_prev(t_slot s);
        return (s == '0) ? t_slot'(DEPTH - 1) : s - 1'b1;
    endfunction

    // Applies one operation to the shadow queue and returns the result it
    // must produce. A push on a full queue and a pop on an empty one leave
    // the contents alone and only raise the status.
    function automatic t_reply deque_apply(dq_pkg::t_op op, dq_pkg::t_data value);
        t_reply r;
        r.popped = '0;
        r.status = dq_pkg::STAT_OK;
        r.front = '0;
        r.back = '0;
        if (op == dq_pkg::OP_PUSH_FRONT || op == dq_pkg::OP_PUSH_BACK) begin
            if (ring_count == t_occ'(DEPTH)) begin
                r.status = dq_pkg::STAT_FULL;
            end else if (op == dq_pkg::OP_PUSH_FRONT) begin
                ring_head = slot_prev(ring_head);
                ring_mem[ring_head] = value;
                ring_count++;
            end else begin
                ring_mem[ring_tail] = value;
                ring_tail = slot_next(ring_tail);
                ring_count++;
            end
        end else begin
            if (ring_count == '0) begin
                r.status = dq_pkg::STAT_EMPTY;
            end else if (op == dq_pkg::OP_POP_FRONT) begin
                r.popped = ring_mem[ring_head];
                ring_head = slot_next(ring_head);
                ring_count--;
            end else begin
                ring_tail = slot_prev(ring_tail);
                r.popped = ring_mem[ring_tail];
                ring_count--;
            end
        end
        r.occupancy = ring_count;
        // Both ends read as zero once the queue has run empty.
        if (ring_count != '0) begin
            r.front = ring_mem[ring_head];
            r.back = ring_mem[slot_prev(ring_tail)];
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("[%0t] %s: got %h, expected %h", $realtime, field, got, want);
        error_count++;
    endtask

    // Compares one observed result with the oldest prediction, field by field.
    task automatic check_reply(t_reply got);
        t_reply want;
        if (replies_due.size() == 0) begin
            report_mismatch("result with none pending, popped", got.popped, '0);
            return;
        end
        want = replies_due.pop_front();
        if (got.popped !== want.popped)
            report_mismatch("popped_value", got.popped, want.popped);
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.occupancy !== want.occupancy)
            report_mismatch("occupancy", 32'(got.occupancy), 32'(want.occupancy));
        if (got.front !== want.front)
            report_mismatch("front_value", got.front, want.front);
        if (got.back !== want.back)
            report_mismatch("back_value", got.back, want.back);
    endtask

    // Draws the idle cycles before the next item on one side. Now and then a
    // calm stretch starts in which that side does not idle at all.
    function automatic int unsigned pick_gap(inout int unsigned calm_left);
        if (calm_left != 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // Adds one operation to the backlog and keeps the planned occupancy.
    task automatic queue_op(dq_pkg::t_op op, dq_pkg::t_data value, bit wait_idle = 1'b0);
        t_queued_op q;
        q.op = op;
        q.value = value;
        q.wait_idle = wait_idle;
        op_backlog.push_back(q);
        if (op == dq_pkg::OP_PUSH_FRONT || op == dq_pkg::OP_PUSH_BACK) begin
            if (planned_count < DEPTH)
                planned_count++;
        end else if (planned_count != 0) begin
            planned_count--;
        end
    endtask

    // Mostly random words, with the extreme values mixed in now and then.
    function automatic dq_pkg::t_data pick_value();
        case ($urandom_range(0, 11))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return '1;
            default: return dq_pkg::t_data'($urandom);
        endcase
    endfunction

    // Sends random operations with the given share of pushes. With a target
    // occupancy, it runs until the plan reaches it and then extra more items;
    // without one, it sends just the extra items. The first item waits until
    // the block has gone idle.
    task automatic random_ops(int unsigned push_pct, int target, int unsigned extra);
        bit first_item;
        dq_pkg::t_op op;
        first_item = 1'b1;
        while ((target >= 0 && planned_count != target) || extra != 0) begin
            if (!(target >= 0 && planned_count != target))
                extra--;
            if ($urandom_range(0, 99) < push_pct)
                op = $urandom_range(0, 1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
            else
                op = $urandom_range(0, 1) ? dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT;
            queue_op(op, pick_value(), first_item);
            first_item = 1'b0;
        end
    endtask

    // Sender: presents the backlog one item at a time, holds an item until it
    // is taken, and idles between items for a drawn number of cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
            // The current item has not been taken yet and stays on the bus.
        end else if (send_gap != 0) begin
            send_gap--;
            s_tvalid <= 1'b0;
        end else if (op_backlog.size() != 0 && !(op_backlog[0].wait_idle &&
                     (replies_due.size() != 0 || (s_tvalid && s_tready)))) begin
            t_queued_op q;
            q = op_backlog.pop_front();
            s_tvalid <= 1'b1;
            s_tdata <= q.value;
            s_tuser <= q.op;
            send_gap = pick_gap(send_calm);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: after each result it stalls for a drawn number of cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            recv_stall = pick_gap(recv_calm);
            m_tready <= (recv_stall == 0);
        end else if (recv_stall != 0) begin
            recv_stall--;
            m_tready <= (recv_stall == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: checks each result taken, then predicts the result of each
    // operation taken. A result always belongs to an earlier operation, so
    // its prediction is already waiting when it is checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                t_reply got;
                got.popped = m_tdata[POPPED_LSB +: dq_pkg::DATA_W];
                got.status = dq_pkg::t_status'(m_tdata[STATUS_LSB +: dq_pkg::STATUS_W]);
                got.occupancy = m_tdata[OCC_LSB +: OCC_W];
                got.front = m_tdata[FRONT_LSB +: dq_pkg::DATA_W];
                got.back = m_tdata[BACK_LSB +: dq_pkg::DATA_W];
                check_reply(got);
            end
            if (s_tvalid && s_tready)
                replies_due.push_back(deque_apply(dq_pkg::t_op'(s_tuser),
                                                  dq_pkg::t_data'(s_tdata)));
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[%0t] timeout with %0d results pending", $realtime, replies_due.size());
            $display("double_ended_queue_test: done, errors");
            $finish;
        end
    end

    initial begin
        // Directed part: errors on an empty queue, extreme items at both
        // ends, pops from each end, and the head and tail wrapping around.
        queue_op(dq_pkg::OP_POP_FRONT, 32'sh1234_5678);
        queue_op(dq_pkg::OP_POP_BACK, '1);
        queue_op(dq_pkg::OP_PUSH_BACK, 32'sh7fff_ffff);
        queue_op(dq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
        queue_op(dq_pkg::OP_PUSH_BACK, '0);
        queue_op(dq_pkg::OP_PUSH_FRONT, '1);
        queue_op(dq_pkg::OP_POP_BACK, '0);
        queue_op(dq_pkg::OP_POP_FRONT, '0);
        queue_op(dq_pkg::OP_POP_FRONT, '0);
        queue_op(dq_pkg::OP_POP_BACK, '0);
        queue_op(dq_pkg::OP_POP_BACK, '0);
        queue_op(dq_pkg::OP_PUSH_FRONT, 32'shaaaa_aaaa);
        queue_op(dq_pkg::OP_POP_BACK, '0);
        queue_op(dq_pkg::OP_PUSH_BACK, 32'sh5555_5555);
        queue_op(dq_pkg::OP_POP_FRONT, '0);
        queue_op(dq_pkg::OP_PUSH_FRONT, 32'sh0000_0001);
        queue_op(dq_pkg::OP_PUSH_FRONT, 32'shffff_fffe);
        queue_op(dq_pkg::OP_PUSH_FRONT, 32'sh0f0f_0f0f);
        queue_op(dq_pkg::OP_POP_BACK, '0);
        queue_op(dq_pkg::OP_POP_BACK, '0);
        queue_op(dq_pkg::OP_POP_BACK, '0);
        queue_op(dq_pkg::OP_POP_FRONT, '0);

        // Random part: a balanced stretch, a push-heavy run into the full
        // queue with rejected pushes, a pop-heavy run down to empty with
        // rejected pops, and a final balanced stretch.
        random_ops(50, -1, 60);
        random_ops(95, DEPTH, 8);
        random_ops(5, 0, 8);
        random_ops(50, -1, 200);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every operation is taken and every result has come.
        while (op_backlog.size() != 0 || s_tvalid || replies_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("double_ended_queue_test: done, clean");
        else
            $display("double_ended_queue_test: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dq_pkg.sv
rtl/dq_store.sv
rtl/dq_ctrl.sv
rtl/double_ended_queue.sv
tb/double_ended_queue_test.sv
